// ===== hw/rtl/ltsc_pkg.sv =====
package ltsc_pkg;

  // table size and derived index width
  localparam int SESSIONS = 1024;
  localparam int IDX_W    = $clog2(SESSIONS);

  // field widths
  localparam int SESS_W  = 10;
  localparam int SEC_W   = 32;
  localparam int MS_W    = 48;
  localparam int TMO_W   = 16;
  localparam int INTV_W  = 32;
  localparam int BATCH_W = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH    = 2'd2;

  localparam logic [TMO_W-1:0]   TMO_RST   = 16'd3;
  localparam logic [INTV_W-1:0]  INTV_RST  = 32'd1000;
  localparam logic [BATCH_W-1:0] BATCH_RST = 7'd64;

  // batch limit: at most 64, never more than the table holds
  localparam int MAX_BATCH = 64;
  localparam int BATCH_CAP = (SESSIONS < MAX_BATCH) ? SESSIONS : MAX_BATCH;

  typedef enum logic [1:0] {
    REQ_CONNECT    = 2'd0,
    REQ_LOGIN      = 2'd1,
    REQ_DISCONNECT = 2'd2,
    REQ_CHECK      = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EV_WR,
    ST_CHECK,
    ST_SCAN
  } state_t;

  // one table entry
  typedef struct packed {
    logic             connected;
    logic             logged_in;
    logic [SEC_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // status from the result queue back to the scan control
  typedef struct packed {
    logic pend_valid;
    logic out_free;
  } oq_status_t;

  function automatic logic timed_out(entry_t e, logic [SEC_W-1:0] now_sec,
                                     logic [TMO_W-1:0] tmo);
    logic [SEC_W-1:0] waited;
    logic             res;
    waited = now_sec - e.stamp;
    if (!e.connected || e.logged_in) begin
      res = 1'b0;
    end else if (now_sec < e.stamp) begin
      res = 1'b0;
    end else begin
      res = (waited >= SEC_W'(tmo));
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/ltsc_req_if.sv =====
interface ltsc_req_if;
  import ltsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [SESS_W-1:0]   session;
  logic [SEC_W-1:0]    time_sec;
  logic [MS_W-1:0]     time_ms;

  modport source (output valid, output req_type, output session, output time_sec,
                  output time_ms, input ready);
  modport sink   (input valid, input req_type, input session, input time_sec,
                  input time_ms, output ready);
endinterface

// ===== hw/rtl/ltsc_res_if.sv =====
interface ltsc_res_if;
  import ltsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [SESS_W-1:0] close_session;
  logic              last;

  modport source (output valid, output close_session, output last, input ready);
  modport sink   (input valid, input close_session, input last, output ready);
endinterface

// ===== hw/rtl/login_timeout_scanner_core.sv =====
// login timeout scanner
// in_ch carries connect, login, disconnect and check requests; out_ch returns
// the index of every session to close, last set on the final close of a check.
// cfg_we/cfg_index/cfg_data write login_timeout_sec (0), check_interval_ms (1)
// and scan_batch (2); other indexes are dropped. write only while idle.
// all session state lives in one table memory (marks plus connect stamp),
// read-modify-written through a registered read port.
// connect, login, disconnect: read, then write back; no result.
// check: an interval test, then one table entry per cycle while out_ch does
// not hold the scan up, for up to 64 entries, then a drain of the last read
// and a flush of the held close, if any. an empty batch or a check turned
// away by the interval test reads no entries. a close is held back one hit
// so the last mark can be set.
// one request is in flight at a time: in_ch.ready is high only when idle.
// after reset a clearing pass writes every one of the 1024 entries, one per
// cycle, with in_ch.ready low; configuration writes are taken meanwhile.
// when a hit meets a held close and out_ch stalls, the scan pauses on the
// current entry with its read data held and resumes as soon as the output register frees up.
module login_timeout_scanner_core (
  input  logic                            clk,
  input  logic                            rst_n,
  ltsc_req_if.sink                        in_ch,
  ltsc_res_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ltsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ltsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ltsc_pkg::*;

  state_t st_r, st_nxt;

  // configuration
  logic [TMO_W-1:0]   tmo_r;
  logic [INTV_W-1:0]  intv_r;
  logic [BATCH_W-1:0] batch_r;

  // latched request
  req_type_t          req_r;
  logic [IDX_W-1:0]   addr_r;
  logic [SEC_W-1:0]   sec_r;
  logic [MS_W-1:0]    ms_r;

  // scan state
  logic [MS_W-1:0]    last_ms_r;
  logic [IDX_W-1:0]   pos_r;
  logic [BATCH_W-1:0] cnt_r;
  logic               dvalid_r;
  logic [IDX_W-1:0]   didx_r;
  logic [IDX_W-1:0]   clr_idx_r;

  // table port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wentry;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  // decode
  logic               in_acc;
  req_type_t          in_req;
  logic [31:0]        sess_ext;
  logic               sess_in_range;
  logic [MS_W-1:0]    ms_diff;
  logic               check_pass;
  logic [BATCH_W-1:0] batch_eff;
  logic [IDX_W-1:0]   pos_inc;

  // scan control
  logic               hit;
  logic               blocked;
  logic               issue;
  logic               consume;
  logic               push;
  logic               flush;
  logic               scan_done;
  oq_status_t         oq;

  assign in_acc        = in_ch.valid && in_ch.ready;
  assign in_req        = req_type_t'(in_ch.req_type);
  assign sess_ext      = 32'(in_ch.session);
  assign sess_in_range = sess_ext < 32'(SESSIONS);
  assign rd_entry      = entry_t'(ram_rdata);

  // rate limit: time must not go back and the interval must have passed
  assign ms_diff    = ms_r - last_ms_r;
  assign check_pass = (ms_r >= last_ms_r) && (ms_diff >= MS_W'(intv_r));

  assign batch_eff = (batch_r > BATCH_W'(BATCH_CAP)) ? BATCH_W'(BATCH_CAP) : batch_r;
  assign pos_inc   = (pos_r == IDX_W'(SESSIONS - 1)) ? '0 : pos_r + 1'b1;

  // scan: one entry read per cycle unless blocked at the output, evaluated the cycle after
  assign hit       = dvalid_r && timed_out(rd_entry, sec_r, tmo_r);
  assign blocked   = hit && oq.pend_valid && !oq.out_free;
  assign scan_done = (cnt_r == '0) && !dvalid_r && (!oq.pend_valid || oq.out_free);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        if (clr_idx_r == IDX_W'(SESSIONS - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req == REQ_CHECK) begin
            st_nxt = ST_CHECK;
          end else if (sess_in_range) begin
            st_nxt = ST_EV_WR;
          end
        end
      end
      ST_EV_WR: begin
        st_nxt = ST_IDLE;
      end
      ST_CHECK: begin
        st_nxt = check_pass ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_done) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and table port
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_r;
    ram_wentry  = rd_entry;
    ram_re      = 1'b0;
    ram_raddr   = pos_r;
    issue       = 1'b0;
    consume     = 1'b0;
    push        = 1'b0;
    flush       = 1'b0;
    case (st_r)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_idx_r;
        ram_wentry = '0;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_re      = in_acc && (in_req != REQ_CHECK) && sess_in_range;
        ram_raddr   = sess_ext[IDX_W-1:0];
      end
      ST_EV_WR: begin
        ram_we = 1'b1;
        case (req_r)
          REQ_CONNECT: begin
            ram_wentry.connected = 1'b1;
            ram_wentry.stamp     = sec_r;
          end
          REQ_LOGIN: begin
            ram_wentry.logged_in = 1'b1;
          end
          REQ_DISCONNECT: begin
            ram_wentry.connected = 1'b0;
            ram_wentry.logged_in = 1'b0;
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      ST_CHECK: begin
        ram_re = 1'b0;
      end
      ST_SCAN: begin
        issue   = (cnt_r != '0) && !blocked;
        ram_re  = issue;
        consume = dvalid_r && !blocked;
        push    = consume && hit;
        flush   = (cnt_r == '0) && !dvalid_r && oq.pend_valid && oq.out_free;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_idx_r <= '0;
      tmo_r     <= TMO_RST;
      intv_r    <= INTV_RST;
      batch_r   <= BATCH_RST;
      last_ms_r <= '0;
      pos_r     <= '0;
      cnt_r     <= '0;
      dvalid_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT:  tmo_r   <= cfg_data[TMO_W-1:0];
          CFG_INTERVAL: intv_r  <= cfg_data[INTV_W-1:0];
          CFG_BATCH:    batch_r <= cfg_data[BATCH_W-1:0];
          default:      ;
        endcase
      end
      if ((st_r == ST_CHECK) && check_pass) begin
        last_ms_r <= ms_r;
        cnt_r     <= batch_eff;
      end
      if (issue) begin
        pos_r    <= pos_inc;
        cnt_r    <= cnt_r - 1'b1;
        dvalid_r <= 1'b1;
      end else if (consume) begin
        dvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_req;
      addr_r <= sess_ext[IDX_W-1:0];
      sec_r  <= in_ch.time_sec;
      ms_r   <= in_ch.time_ms;
    end
    if (issue) begin
      didx_r <= pos_r;
    end
  end

  ltsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SESSIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ltsc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_idx (didx_r),
    .flush    (flush),
    .status   (oq),
    .out_ch   (out_ch)
  );

  // read data in flight only belongs to a running scan
  a_dvalid_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dvalid_r |-> (st_r == ST_SCAN))
    else $error("scan read data pending outside a scan");

  // a stalled scan must not advance its read pointer
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_SCAN) && blocked) |=> ($stable(pos_r) && $stable(cnt_r)))
    else $error("scan advanced while blocked on output");

  // the scan never leaves the table or overruns its batch
  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(pos_r) < 32'(SESSIONS)) && (32'(cnt_r) <= 32'(BATCH_CAP)))
    else $error("scan position or count out of range");

endmodule

// ===== hw/rtl/ltsc_ram.sv =====
module ltsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ltsc_outq.sv =====
module ltsc_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [ltsc_pkg::IDX_W-1:0] push_idx,
  input  logic                       flush,
  output ltsc_pkg::oq_status_t       status,
  ltsc_res_if.source                 out_ch
);
  import ltsc_pkg::*;

  logic             pend_valid_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_last_r;
  logic             out_free;
  logic             emit;
  logic [31:0]      idx_ext;

  // one hit is held back until the next hit or the end of the batch
  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = (push && pend_valid_r) || flush;

  assign status.pend_valid = pend_valid_r;
  assign status.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (push) begin
        pend_valid_r <= 1'b1;
      end else if (flush) begin
        pend_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pend_idx_r <= push_idx;
    end
    if (out_free && emit) begin
      out_idx_r  <= pend_idx_r;
      out_last_r <= flush;
    end
  end

  assign idx_ext              = 32'(out_idx_r);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.close_session = idx_ext[SESS_W-1:0];
  assign out_ch.last          = out_last_r;

  // a held hit is only replaced when the output stage can take it
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pend_valid_r) |-> out_free)
    else $error("hit pushed while held hit cannot move out");

  a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
    flush |-> (pend_valid_r && out_free && !push))
    else $error("end-of-batch flush without a held hit or output room");

  // a waiting close holds its payload until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=>
      (out_valid_r && $stable(out_idx_r) && $stable(out_last_r)))
    else $error("close changed while stalled");

endmodule
